// ===== sv/occ_pkg.sv =====
// shared types and constants of the occupancy step block
// no dependencies
`default_nettype none
package occ_pkg;

    localparam int PROB_FRAC_BITS     = 16;
    localparam int PROB_W             = PROB_FRAC_BITS + 1;
    localparam int MAX_STEPS_PER_HOUR = 60;
    localparam int STEPS_W            = 6;
    localparam int MOB_W              = 16;
    localparam int MOB_SHIFT          = 4;
    localparam int SAMPLE_W           = 16;
    localparam int BETA_FRAC          = 16;
    localparam int BETA_W             = 24;
    localparam int DIV_NW             = PROB_W + BETA_W + 1;
    localparam int DIV_DW             = BETA_W + 1;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 16;

    localparam logic [PROB_W-1:0]  PROB_ONE  = PROB_W'(1) << PROB_FRAC_BITS;
    localparam logic [BETA_W-1:0]  BETA_ONE  = BETA_W'(1) << BETA_FRAC;
    localparam logic [BETA_W-1:0]  BETA_MAX  = {BETA_W{1'b1}};
    localparam logic [STEPS_W-1:0] MAX_STEPS = STEPS_W'(MAX_STEPS_PER_HOUR);
    localparam logic [STEPS_W-1:0] STEPS_RST = STEPS_W'(1);
    localparam logic [MOB_W-1:0]   MOB_RST   = MOB_W'(451);

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STEPS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOBILITY = CFG_IDX_W'(1);

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_GO_PC,
        CMD_GET_PC,
        CMD_GO_PN,
        CMD_GET_PN,
        CMD_SPECIAL,
        CMD_GO_LOW,
        CMD_GET_LOW,
        CMD_GO_BND,
        CMD_GET_BND,
        CMD_MUL01,
        CMD_GO_T01,
        CMD_GET_T01,
        CMD_MUL11,
        CMD_GO_T11,
        CMD_GET_T11,
        CMD_DRAW
    } t_cmd;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PC_GO,
        ST_PC_WAIT,
        ST_PN_GO,
        ST_PN_WAIT,
        ST_CLASSIFY,
        ST_LOW_GO,
        ST_LOW_WAIT,
        ST_BND_GO,
        ST_BND_WAIT,
        ST_MUL01,
        ST_T01_GO,
        ST_T01_WAIT,
        ST_MUL11,
        ST_T11_GO,
        ST_T11_WAIT,
        ST_DRAW
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic div_start;
    } t_ctrl;

    typedef struct packed {
        logic div_done;
        logic special;
        logic equal;
        logic skip_bound;
        logic present;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

// ===== sv/occ_in_if.sv =====
// input channel: one simulated time step per transaction
// depends on occ_pkg
`default_nettype none
interface occ_in_if;
    logic                          valid;
    logic                          ready;
    logic [occ_pkg::PROB_W-1:0]    p_hour;
    logic [occ_pkg::PROB_W-1:0]    p_next_hour;
    logic [occ_pkg::STEPS_W-1:0]   step_in_hour;
    logic [occ_pkg::SAMPLE_W-1:0]  random_sample;

    modport source(output valid, p_hour, p_next_hour, step_in_hour, random_sample,
                   input ready);
    modport sink(input valid, p_hour, p_next_hour, step_in_hour, random_sample,
                 output ready);
endinterface
`default_nettype wire

// ===== sv/occ_out_if.sv =====
// output channel: occupied flag and interpolated probability
// depends on occ_pkg
`default_nettype none
interface occ_out_if;
    logic                        valid;
    logic                        ready;
    logic                        occupied;
    logic [occ_pkg::PROB_W-1:0]  p_current;

    modport source(output valid, occupied, p_current, input ready);
    modport sink(input valid, occupied, p_current, output ready);
endinterface
`default_nettype wire

// ===== sv/occ_cfg_if.sv =====
// configuration write channel: register index and data
// depends on occ_pkg
`default_nettype none
interface occ_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [occ_pkg::CFG_IDX_W-1:0]  index;
    logic [occ_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/occ_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// standalone, no package use
`default_nettype none
module occ_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_quo, n_quo;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DEN_W:0]   w_shift;
    logic             w_fit;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_fit   = w_shift >= {1'b0, r_den};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_quo  = i_num;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_fit ? DEN_W'(w_shift - {1'b0, r_den}) : w_shift[DEN_W-1:0];
            n_quo = {r_quo[NUM_W-2:0], w_fit};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule
`default_nettype wire

// ===== sv/occ_dp.sv =====
// datapath: config registers, interpolation, beta clamp, transition draw
// depends on occ_pkg and occ_div
`default_nettype none
module occ_dp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire occ_pkg::t_ctrl                  i_ctrl,
    output occ_pkg::t_status                     o_status,
    input  wire logic [occ_pkg::PROB_W-1:0]      i_p_hour,
    input  wire logic [occ_pkg::PROB_W-1:0]      i_p_next_hour,
    input  wire logic [occ_pkg::STEPS_W-1:0]     i_step_in_hour,
    input  wire logic [occ_pkg::SAMPLE_W-1:0]    i_random_sample,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [occ_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [occ_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic                                 o_occupied,
    output logic [occ_pkg::PROB_W-1:0]           o_p_current
);
    localparam int P   = occ_pkg::PROB_FRAC_BITS;
    localparam int PW  = occ_pkg::PROB_W;
    localparam int SW  = occ_pkg::STEPS_W;
    localparam int BW  = occ_pkg::BETA_W;
    localparam int NW  = occ_pkg::DIV_NW;
    localparam int DW  = occ_pkg::DIV_DW;
    localparam int IW  = SW + PW + 2;
    localparam int DRW = PW + occ_pkg::SAMPLE_W;
    localparam logic [PW-1:0] PONE = occ_pkg::PROB_ONE;
    localparam logic [PW:0]   ONEX = {1'b0, occ_pkg::PROB_ONE};

    logic [SW-1:0]                 r_steps;
    logic [occ_pkg::MOB_W-1:0]     r_mob;
    logic                          r_present;
    logic [PW-1:0]                 r_ph, r_pnh, r_pc, r_pn, r_t01, r_t;
    logic [SW-1:0]                 r_s, r_f;
    logic [occ_pkg::SAMPLE_W-1:0]  r_sample;
    logic [BW-1:0]                 r_beta;
    logic                          r_lowered, r_neg;
    logic [NW-1:0]                 r_prod;
    logic                          r_out_valid, r_occ;
    logic [PW-1:0]                 r_pcur;

    logic          w_div_done;
    logic [NW-1:0] w_quot, w_num;
    logic [DW-1:0] w_den;
    logic [SW-1:0] w_s_cl, w_sf, w_sf1;
    logic [SW:0]   w_f1;
    logic [IW-1:0] w_ipc, w_ipn;
    logic [PW:0]   w_sum, w_low_b, w_bnd_a, w_bnd_b;
    logic [PW-1:0] w_low_a;
    logic          w_eq, w_sum_gt, w_sum_one, w_special, w_out_free;
    logic [DW-1:0] w_bden;
    logic [NW-1:0] w_t11_lhs, w_prod, w_add;
    logic [PW-1:0] w_mul_a;
    logic [BW:0]   w_mul_b;
    logic [BW-1:0] w_beta_q, w_shuff;
    logic [PW-1:0] w_q_sat, w_t01, w_spec_t;
    logic [DRW-1:0] w_lhs, w_rhs01, w_rhs11;
    logic          w_next_present;
    logic          w_out_load;

    assign w_shuff = BW'(r_mob) << occ_pkg::MOB_SHIFT;
    assign w_s_cl  = (r_steps == '0) ? SW'(1)
                   : ((r_steps > occ_pkg::MAX_STEPS) ? occ_pkg::MAX_STEPS : r_steps);

    // interpolation weights
    assign w_sf  = r_s - r_f;
    assign w_sf1 = w_sf - SW'(1);
    assign w_f1  = {1'b0, r_f} + (SW+1)'(1);
    assign w_ipc = IW'(w_sf) * IW'(r_ph) + IW'(r_f) * IW'(r_pnh);
    assign w_ipn = IW'(w_sf1) * IW'(r_ph) + IW'(w_f1) * IW'(r_pnh);

    // classification and beta bound operands
    assign w_sum     = {1'b0, r_pc} + {1'b0, r_pn};
    assign w_eq      = r_pc == r_pn;
    assign w_sum_gt  = w_sum > ONEX;
    assign w_sum_one = w_sum == ONEX;
    assign w_special = (r_pn == '0) || (r_pn == PONE) || (r_pc == PONE) || (r_pc == '0);
    assign w_low_a   = (r_pc < r_pn) ? (r_pn - r_pc) : (r_pc - r_pn);
    assign w_low_b   = (r_pc < r_pn) ? ({PONE, 1'b0} - w_sum) : w_sum;
    assign w_bnd_a   = w_sum_gt ? ({1'b0, r_pc} + ONEX - {1'b0, r_pn})
                                : (ONEX - {1'b0, r_pc} + {1'b0, r_pn});
    assign w_bnd_b   = w_sum_gt ? (w_sum - ONEX) : (ONEX - w_sum);
    assign w_bden    = DW'(r_beta) + DW'(occ_pkg::BETA_ONE);
    assign w_t11_lhs = NW'(r_pn) << P;

    // divider operand select
    always_comb begin
        w_num = '0;
        w_den = '0;
        case (i_ctrl.cmd)
            occ_pkg::CMD_GO_PC: begin
                w_num = NW'(w_ipc) + NW'(r_s >> 1);
                w_den = DW'(r_s);
            end
            occ_pkg::CMD_GO_PN: begin
                w_num = NW'(w_ipn) + NW'(r_s >> 1);
                w_den = DW'(r_s);
            end
            occ_pkg::CMD_GO_LOW: begin
                w_num = NW'(w_low_a) << occ_pkg::BETA_FRAC;
                w_den = DW'(w_low_b);
            end
            occ_pkg::CMD_GO_BND: begin
                w_num = NW'(w_bnd_a) << occ_pkg::BETA_FRAC;
                w_den = DW'(w_bnd_b);
            end
            occ_pkg::CMD_GO_T01: begin
                w_num = r_prod + NW'(w_bden >> 1);
                w_den = w_bden;
            end
            occ_pkg::CMD_GO_T11: begin
                w_num = w_t11_lhs - r_prod + NW'(r_pc >> 1);
                w_den = DW'(r_pc);
            end
            default: begin
                w_num = '0;
                w_den = '0;
            end
        endcase
    end

    occ_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctrl.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // shared multiplier
    always_comb begin
        if (i_ctrl.cmd == occ_pkg::CMD_MUL11) begin
            w_mul_a = PONE - r_pc;
            w_mul_b = (BW+1)'(r_t01);
        end else begin
            w_mul_a = r_pc;
            if (w_eq) begin
                w_mul_b = {r_beta, 1'b0};
            end else if (r_beta >= occ_pkg::BETA_ONE) begin
                w_mul_b = {1'b0, r_beta - occ_pkg::BETA_ONE};
            end else begin
                w_mul_b = {1'b0, occ_pkg::BETA_ONE - r_beta};
            end
        end
    end
    assign w_prod = NW'(w_mul_a) * NW'(w_mul_b);

    // quotient post-processing
    assign w_beta_q = (w_quot > NW'(occ_pkg::BETA_MAX)) ? occ_pkg::BETA_MAX : w_quot[BW-1:0];
    assign w_q_sat  = (w_quot > NW'(PONE)) ? PONE : w_quot[PW-1:0];
    assign w_add    = w_quot + NW'(r_pn);
    always_comb begin
        if (w_eq) begin
            w_t01 = w_q_sat;
        end else if (r_neg) begin
            w_t01 = (w_quot >= NW'(r_pn)) ? '0 : (r_pn - w_quot[PW-1:0]);
        end else begin
            w_t01 = (w_add > NW'(PONE)) ? PONE : w_add[PW-1:0];
        end
    end

    always_comb begin
        if (r_pn == '0) begin
            w_spec_t = '0;
        end else if (r_pn == PONE) begin
            w_spec_t = PONE;
        end else if (r_pc == PONE) begin
            w_spec_t = r_present ? r_pn : '0;
        end else begin
            w_spec_t = r_present ? '0 : r_pn;
        end
    end

    // draw against the sample
    assign w_lhs          = DRW'(r_sample) << P;
    assign w_rhs01        = DRW'(r_t) << occ_pkg::SAMPLE_W;
    assign w_rhs11        = DRW'(PONE - r_t) << occ_pkg::SAMPLE_W;
    assign w_next_present = r_present ? !(w_lhs < w_rhs11) : (w_lhs < w_rhs01);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = i_ctrl.cmd == occ_pkg::CMD_DRAW;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps     <= occ_pkg::STEPS_RST;
            r_mob       <= occ_pkg::MOB_RST;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    occ_pkg::CFG_IDX_STEPS:    r_steps <= i_cfg_data[SW-1:0];
                    occ_pkg::CFG_IDX_MOBILITY: r_mob   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_out_load) begin
                r_present   <= w_next_present;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        case (i_ctrl.cmd)
            occ_pkg::CMD_LOAD: begin
                r_ph      <= (i_p_hour > PONE) ? PONE : i_p_hour;
                r_pnh     <= (i_p_next_hour > PONE) ? PONE : i_p_next_hour;
                r_s       <= w_s_cl;
                r_f       <= (i_step_in_hour >= w_s_cl) ? (w_s_cl - SW'(1)) : i_step_in_hour;
                r_sample  <= i_random_sample;
                r_beta    <= w_shuff;
                r_lowered <= 1'b0;
            end
            occ_pkg::CMD_GET_PC:  r_pc <= w_quot[PW-1:0];
            occ_pkg::CMD_GET_PN:  r_pn <= w_quot[PW-1:0];
            occ_pkg::CMD_SPECIAL: r_t  <= w_spec_t;
            occ_pkg::CMD_GET_LOW: begin
                if (r_beta < w_beta_q) begin
                    r_beta    <= w_beta_q;
                    r_lowered <= 1'b1;
                end
            end
            occ_pkg::CMD_GET_BND: begin
                if (r_beta > w_beta_q) begin
                    r_beta <= w_beta_q;
                end
            end
            occ_pkg::CMD_MUL01: begin
                r_prod <= w_prod;
                r_neg  <= !w_eq && (r_beta < occ_pkg::BETA_ONE);
            end
            occ_pkg::CMD_GET_T01: begin
                r_t01 <= w_t01;
                r_t   <= w_t01;
            end
            occ_pkg::CMD_MUL11:  r_prod <= w_prod;
            occ_pkg::CMD_GO_T11: r_neg  <= w_t11_lhs < r_prod;
            occ_pkg::CMD_GET_T11: r_t   <= r_neg ? '0 : w_q_sat;
            occ_pkg::CMD_DRAW: begin
                r_occ  <= w_next_present;
                r_pcur <= r_pc;
            end
            default: begin
            end
        endcase
    end

    assign o_status.div_done   = w_div_done;
    assign o_status.special    = w_special;
    assign o_status.equal      = w_eq;
    assign o_status.skip_bound = r_lowered || w_sum_one;
    assign o_status.present    = r_present;
    assign o_status.out_free   = w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_occupied  = r_occ;
    assign o_p_current = r_pcur;
endmodule
`default_nettype wire

// ===== sv/occ_ctrl.sv =====
// controller: sequences the divisions of one step
// depends on occ_pkg
`default_nettype none
module occ_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire occ_pkg::t_status i_status,
    output occ_pkg::t_ctrl        o_ctrl
);
    occ_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= occ_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            occ_pkg::ST_IDLE:     if (i_in_valid) n_state = occ_pkg::ST_PC_GO;
            occ_pkg::ST_PC_GO:    n_state = occ_pkg::ST_PC_WAIT;
            occ_pkg::ST_PC_WAIT:  if (i_status.div_done) n_state = occ_pkg::ST_PN_GO;
            occ_pkg::ST_PN_GO:    n_state = occ_pkg::ST_PN_WAIT;
            occ_pkg::ST_PN_WAIT:  if (i_status.div_done) n_state = occ_pkg::ST_CLASSIFY;
            occ_pkg::ST_CLASSIFY: begin
                if (i_status.special) begin
                    n_state = occ_pkg::ST_DRAW;
                end else if (i_status.equal) begin
                    n_state = occ_pkg::ST_BND_GO;
                end else begin
                    n_state = occ_pkg::ST_LOW_GO;
                end
            end
            occ_pkg::ST_LOW_GO:   n_state = occ_pkg::ST_LOW_WAIT;
            occ_pkg::ST_LOW_WAIT: if (i_status.div_done) n_state = occ_pkg::ST_BND_GO;
            occ_pkg::ST_BND_GO: begin
                n_state = i_status.skip_bound ? occ_pkg::ST_MUL01 : occ_pkg::ST_BND_WAIT;
            end
            occ_pkg::ST_BND_WAIT: if (i_status.div_done) n_state = occ_pkg::ST_MUL01;
            occ_pkg::ST_MUL01:    n_state = occ_pkg::ST_T01_GO;
            occ_pkg::ST_T01_GO:   n_state = occ_pkg::ST_T01_WAIT;
            occ_pkg::ST_T01_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.present ? occ_pkg::ST_MUL11 : occ_pkg::ST_DRAW;
                end
            end
            occ_pkg::ST_MUL11:    n_state = occ_pkg::ST_T11_GO;
            occ_pkg::ST_T11_GO:   n_state = occ_pkg::ST_T11_WAIT;
            occ_pkg::ST_T11_WAIT: if (i_status.div_done) n_state = occ_pkg::ST_DRAW;
            occ_pkg::ST_DRAW:     if (i_status.out_free) n_state = occ_pkg::ST_IDLE;
            default:              n_state = occ_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready       = 1'b0;
        o_ctrl.cmd       = occ_pkg::CMD_NONE;
        o_ctrl.div_start = 1'b0;
        case (r_state)
            occ_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.cmd = occ_pkg::CMD_LOAD;
            end
            occ_pkg::ST_PC_GO: begin
                o_ctrl.cmd       = occ_pkg::CMD_GO_PC;
                o_ctrl.div_start = 1'b1;
            end
            occ_pkg::ST_PC_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_PC;
            occ_pkg::ST_PN_GO: begin
                o_ctrl.cmd       = occ_pkg::CMD_GO_PN;
                o_ctrl.div_start = 1'b1;
            end
            occ_pkg::ST_PN_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_PN;
            occ_pkg::ST_CLASSIFY: if (i_status.special) o_ctrl.cmd = occ_pkg::CMD_SPECIAL;
            occ_pkg::ST_LOW_GO: begin
                o_ctrl.cmd       = occ_pkg::CMD_GO_LOW;
                o_ctrl.div_start = 1'b1;
            end
            occ_pkg::ST_LOW_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_LOW;
            occ_pkg::ST_BND_GO: begin
                if (!i_status.skip_bound) begin
                    o_ctrl.cmd       = occ_pkg::CMD_GO_BND;
                    o_ctrl.div_start = 1'b1;
                end
            end
            occ_pkg::ST_BND_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_BND;
            occ_pkg::ST_MUL01: o_ctrl.cmd = occ_pkg::CMD_MUL01;
            occ_pkg::ST_T01_GO: begin
                o_ctrl.cmd       = occ_pkg::CMD_GO_T01;
                o_ctrl.div_start = 1'b1;
            end
            occ_pkg::ST_T01_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_T01;
            occ_pkg::ST_MUL11: o_ctrl.cmd = occ_pkg::CMD_MUL11;
            occ_pkg::ST_T11_GO: begin
                o_ctrl.cmd       = occ_pkg::CMD_GO_T11;
                o_ctrl.div_start = 1'b1;
            end
            occ_pkg::ST_T11_WAIT: if (i_status.div_done) o_ctrl.cmd = occ_pkg::CMD_GET_T11;
            occ_pkg::ST_DRAW: if (i_status.out_free) o_ctrl.cmd = occ_pkg::CMD_DRAW;
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

// ===== sv/occupancy_markov_step.sv =====
// top level of the occupancy presence step: controller, datapath, assertions
// depends on occ_pkg, the channel interfaces, occ_ctrl and occ_dp
//
// channel  dir  handshake     payload
// i_in     in   valid/ready   p_hour, p_next_hour, step_in_hour, random_sample
// o_out    out  valid/ready   occupied, p_current
// i_cfg    in   valid/ready   index, data (ready always high)
//
// one step at a time; a special probability settles the transition after the two interpolation
// divisions, while the full beta clamp and stay-present path run up to six divisions
// each division runs start, one divider iteration per quotient bit (42 bits), result
// a finished result waits in the output register while the next step is taken
// synchronous active-low reset: absent, steps_per_hour 1, mobility 451
`default_nettype none
module occupancy_markov_step (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    occ_in_if.sink     i_in,
    occ_out_if.source  o_out,
    occ_cfg_if.sink    i_cfg
);
    occ_pkg::t_ctrl   w_ctrl;
    occ_pkg::t_status w_status;

    occ_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl)
    );

    occ_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .o_status        (w_status),
        .i_p_hour        (i_in.p_hour),
        .i_p_next_hour   (i_in.p_next_hour),
        .i_step_in_hour  (i_in.step_in_hour),
        .i_random_sample (i_in.random_sample),
        .i_cfg_valid     (i_cfg.valid),
        .o_cfg_ready     (i_cfg.ready),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_occupied      (o_out.occupied),
        .o_p_current     (o_out.p_current)
    );

`ifndef SYNTHESIS
    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second transaction taken while a step is in progress");

    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.p_current <= occ_pkg::PROB_ONE))
        else $error("p_current above one");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/occ_tb_if.sv =====
// no extra interfaces needed beyond the rtl ones; this file holds testbench-side item types
// depends on occ_pkg
`timescale 1ns / 100ps
package occ_tb_pkg;
    import occ_pkg::*;

    typedef struct packed {
        logic [PROB_W-1:0]   p_hour;
        logic [PROB_W-1:0]   p_next_hour;
        logic [STEPS_W-1:0]  step_in_hour;
        logic [SAMPLE_W-1:0] random_sample;
    } t_step_item;

    typedef struct packed {
        logic              occupied;
        logic [PROB_W-1:0] p_current;
    } t_occ_result;
endpackage

// ===== tb/sv/testbench.sv =====
// testbench of occupancy_markov_step: random and directed time steps checked against
// an in-bench presence model; depends on occ_pkg, occ_tb_pkg and the channel interfaces
`timescale 1ns / 100ps
module testbench;
    import occ_pkg::*;
    import occ_tb_pkg::*;

    localparam longint ONE = 65536;
    localparam longint BONE = 65536;
    localparam longint BMAX = 24'hFFFFFF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;

    occ_in_if  in_ch();
    occ_out_if out_ch();
    occ_cfg_if cfg_ch();

    occupancy_markov_step i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(in_ch.sink), .o_out(out_ch.source), .i_cfg(cfg_ch.sink)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    t_step_item  pending_steps[$];
    t_occ_result expected_results[$];
    logic [STEPS_W-1:0] model_steps = STEPS_RST;
    logic [MOB_W-1:0]   model_mobility = MOB_RST;
    logic               model_present = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int mismatches = 0;
    int idle_cycles = 0;

    function automatic longint near_div(longint n, longint d);
        if (d == 0) return 0;
        return (n + d / 2) / d;
    endfunction

    function automatic longint beta_ratio(longint a, longint b);
        longint r;
        if (b == 0) return BMAX;
        r = (a << 16) / b;
        return r > BMAX ? BMAX : r;
    endfunction

    function automatic longint enter_prob(longint pc, longint pn, longint shuff);
        longint beta, sum, lower, bound, num, mag, q;
        beta = shuff;
        if (pn == 0) return 0;
        if (pn == ONE) return ONE;
        if (pc == ONE) return 0;
        if (pc == 0) return pn;
        sum = pc + pn;
        if (pc == pn) begin
            if (sum > ONE) begin
                bound = beta_ratio(ONE, 2 * pc - ONE);
                if (shuff > bound) beta = bound;
            end else if (sum < ONE) begin
                bound = beta_ratio(ONE, ONE - 2 * pc);
                if (shuff > bound) beta = bound;
            end
            q = near_div(2 * beta * pc, beta + BONE);
            return q > ONE ? ONE : q;
        end
        if (pc < pn) lower = beta_ratio(pn - pc, 2 * ONE - sum);
        else lower = beta_ratio(pc - pn, sum);
        if (shuff < lower) begin
            beta = lower;
        end else if (sum > ONE) begin
            bound = beta_ratio(pc + ONE - pn, sum - ONE);
            if (shuff > bound) beta = bound;
        end else if (sum < ONE) begin
            bound = beta_ratio(ONE - pc + pn, ONE - sum);
            if (shuff > bound) beta = bound;
        end
        num = pc * (beta - BONE);
        mag = num < 0 ? -num : num;
        q = near_div(mag, beta + BONE);
        if (num < 0) return q >= pn ? 0 : pn - q;
        q += pn;
        return q > ONE ? ONE : q;
    endfunction

    function automatic longint stay_prob(longint pc, longint pn, longint shuff);
        longint num, q;
        if (pn == 0) return 0;
        if (pn == ONE) return ONE;
        if (pc == ONE) return pn;
        if (pc == 0) return 0;
        num = pn * ONE - (ONE - pc) * enter_prob(pc, pn, shuff);
        if (num < 0) return 0;
        q = near_div(num, pc);
        return q > ONE ? ONE : q;
    endfunction

    function automatic t_occ_result predict_step(t_step_item it);
        longint ph, pnh, f, s, smp, pc, pn, t;
        t_occ_result r;
        ph = it.p_hour; pnh = it.p_next_hour;
        f = it.step_in_hour; smp = it.random_sample;
        s = model_steps;
        if (ph > ONE) ph = ONE;
        if (pnh > ONE) pnh = ONE;
        if (s == 0) s = 1;
        if (s > MAX_STEPS_PER_HOUR) s = MAX_STEPS_PER_HOUR;
        if (f >= s) f = s - 1;
        pc = near_div((s - f) * ph + f * pnh, s);
        pn = near_div((s - f - 1) * ph + (f + 1) * pnh, s);
        if (!model_present) begin
            t = enter_prob(pc, pn, longint'(model_mobility) << 4);
            model_present = smp < t;
        end else begin
            t = stay_prob(pc, pn, longint'(model_mobility) << 4);
            model_present = !(smp < ONE - t);
        end
        r.occupied = model_present;
        r.p_current = pc[PROB_W-1:0];
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_step_item it;
                it = pending_steps.pop_front();
                expected_results.insert(expected_results.size(), predict_step(it));
                in_ch.valid         <= 1'b1;
                in_ch.p_hour        <= it.p_hour;
                in_ch.p_next_hour   <= it.p_next_hour;
                in_ch.step_in_hour  <= it.step_in_hour;
                in_ch.random_sample <= it.random_sample;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure, with a long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                t_occ_result e;
                e = expected_results.pop_front();
                if (e.occupied !== out_ch.occupied || e.p_current !== out_ch.p_current) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected occ=%0d pc=%0d got occ=%0d pc=%0d",
                                 e.occupied, e.p_current, out_ch.occupied, out_ch.p_current);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_IDX_STEPS) model_steps = val[STEPS_W-1:0];
        else model_mobility = val;
    endtask

    task automatic wait_drained();
        while (pending_steps.size() > 0 || expected_results.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [PROB_W-1:0] rand_prob();
        case ($urandom_range(9))
            0: return '0;
            1: return PROB_ONE;
            2: return PROB_W'($urandom_range(131071));
            3: return PROB_W'($urandom_range(65535, 65536));
            default: return PROB_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic push_step(logic [PROB_W-1:0] ph, logic [PROB_W-1:0] pn,
                             logic [STEPS_W-1:0] f, logic [SAMPLE_W-1:0] smp);
        t_step_item it;
        it.p_hour = ph; it.p_next_hour = pn; it.step_in_hour = f; it.random_sample = smp;
        pending_steps.insert(pending_steps.size(), it);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            logic [STEPS_W-1:0] f;
            logic [PROB_W-1:0] a;
            f = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
            a = rand_prob();
            push_step(a, ($urandom_range(5) == 0) ? a : rand_prob(), f, 16'($urandom));
        end
    endtask

    initial begin
        in_ch.valid = 0; in_ch.p_hour = 0; in_ch.p_next_hour = 0;
        in_ch.step_in_hour = 0; in_ch.random_sample = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0; cfg_ch.index = CFG_IDX_STEPS; cfg_ch.data = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes and special probabilities at reset settings, then at other step and mobility settings
        push_step(0, 0, 0, 0);
        push_step(ONE, ONE, 0, 16'hFFFF);
        push_step(17'h1FFFF, 17'h1FFFF, 6'h3F, 0);
        push_step(ONE, 32768, 0, 16'hFFFF);
        push_step(0, 32768, 0, 0);
        push_step(32768, 32768, 0, 100);
        push_step(50000, 50000, 0, 30000);
        push_step(10000, 10000, 0, 5000);
        push_step(20000, 50000, 0, 40000);
        push_step(50000, 20000, 0, 1000);
        push_step(65535, 1, 0, 65535);
        push_step(1, 65535, 0, 0);
        wait_drained();
        write_reg(CFG_IDX_STEPS, 0);
        write_reg(CFG_IDX_MOBILITY, 16'hFFFF);
        push_step(30000, 60000, 5, 20000);
        push_step(60000, 30000, 0, 50000);
        push_step(40000, 40000, 0, 1);
        wait_drained();
        write_reg(CFG_IDX_STEPS, 63);
        write_reg(CFG_IDX_MOBILITY, 0);
        push_step(30000, 60000, 59, 20000);
        push_step(60000, 30000, 63, 50000);
        push_step(ONE, 0, 30, 7);
        wait_drained();

        // random phase one: sender idles little, receiver much
        send_idle_pct = 29; recv_idle_pct = 88;
        write_reg(CFG_IDX_STEPS, 4);
        write_reg(CFG_IDX_MOBILITY, 451);
        random_phase(300);
        wait_drained();
        write_reg(CFG_IDX_STEPS, 60);
        write_reg(CFG_IDX_MOBILITY, 16'($urandom));
        random_phase(300);
        wait_drained();

        // phase two: roles swapped, with a long receiver hold-off
        send_idle_pct = 88; recv_idle_pct = 29;
        write_reg(CFG_IDX_STEPS, 6'($urandom_range(1, 60)));
        write_reg(CFG_IDX_MOBILITY, 16'($urandom_range(4095)));
        hold_off = 3000;
        random_phase(300);
        wait_drained();
        write_reg(CFG_IDX_STEPS, 1);
        write_reg(CFG_IDX_MOBILITY, 16'($urandom));
        random_phase(300);
        wait_drained();

        // phase three: no idling
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_IDX_STEPS, 6'($urandom_range(1, 60)));
        write_reg(CFG_IDX_MOBILITY, 16'($urandom));
        random_phase(300);
        wait_drained();
        write_reg(CFG_IDX_STEPS, 12);
        write_reg(CFG_IDX_MOBILITY, 16'($urandom_range(200, 1000)));
        random_phase(300);
        wait_drained();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
